// ----- hdl/yuvnv_pkg.sv -----
// Shared types and constants for the YUV 4:2:0 to NV21 address generator.
// Holds the command, status and phase codes and the transaction structs.
// No dependencies.
package yuvnv_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 8192;
   localparam int MAX_HEIGHT_DEFAULT = 8192;
   localparam int ADDR_BITS_DEFAULT  = 32;

   // Width of the row-check sums: a 32-bit start plus the row and column terms.
   localparam int SUM_BITS = 34;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_STEP  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_BAD_DIMS      = 3'd1,
      ST_BAD_SIZE      = 3'd2,
      ST_LUMA_BOUNDS   = 3'd3,
      ST_CHROMA_BOUNDS = 3'd4,
      ST_IDLE          = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_LUMA   = 2'd1,
      PH_CHROMA = 2'd2
   } phase_type;

   localparam logic [1:0] PLANE_Y = 2'd0;
   localparam logic [1:0] PLANE_U = 2'd1;
   localparam logic [1:0] PLANE_V = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [1:0]  plane_sel;
      logic [31:0] plane_start;
      logic [31:0] plane_end;
      logic [15:0] line_pitch;
      logic [7:0]  sample_pitch;
      logic [13:0] crop_x;
      logic [13:0] crop_y;
      logic [13:0] frame_width;
      logic [13:0] frame_height;
      logic [31:0] out_bytes;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        byte_valid;
      logic [1:0]  src_plane;
      logic [31:0] src_offset;
      logic [31:0] dst_offset;
      logic        frame_last;
   } rsp_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] first;
   } row_chk_type;

endpackage

// ----- hdl/yuv420_to_nv21_address_generator.sv -----
// Top level of the YUV 4:2:0 to NV21 address generator: descriptor store,
// frame walker and row bounds checks between an input and a result register.
// Depends on yuvnv_pkg.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid, req_stall | req_data (yuvnv_pkg::req_type)
//   rsp     | out       | rsp_valid, rsp_stall | rsp_data (yuvnv_pkg::rsp_type)
//
// Every transaction yields exactly one result, via the input and then the result
// register. A new transaction is taken every cycle unless rsp stalls; the row-start
// multiplies and bounds compare sit in the single stage between the two registers.
// Reset clears the descriptors and the walker; the block comes up idle.
// A stall on rsp holds the result register and, through it, the input register.
module yuv420_to_nv21_address_generator #(
   parameter int MAX_WIDTH  = yuvnv_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = yuvnv_pkg::MAX_HEIGHT_DEFAULT,
   parameter int ADDR_BITS  = yuvnv_pkg::ADDR_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  yuvnv_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output yuvnv_pkg::rsp_type rsp_data
);

   localparam int DESC_BITS = (ADDR_BITS < 32) ? ADDR_BITS : 32;
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ROW_BITS  = $clog2(MAX_HEIGHT);

   logic               in_valid_ff;
   yuvnv_pkg::req_type in_data_ff;
   logic               out_valid_ff;
   yuvnv_pkg::rsp_type out_data_ff;
   yuvnv_pkg::rsp_type rsp_in;
   logic               advance;

   logic [DESC_BITS-1:0] desc_start_ff [3];
   logic [DESC_BITS-1:0] desc_start_in [3];
   logic [DESC_BITS-1:0] desc_end_ff [3];
   logic [DESC_BITS-1:0] desc_end_in [3];
   logic [15:0]          desc_lp_ff [3];
   logic [15:0]          desc_lp_in [3];
   logic [7:0]           desc_sp_ff [3];
   logic [7:0]           desc_sp_in [3];

   logic [13:0] crop_x_ff, crop_x_in, crop_y_ff, crop_y_in;
   logic [13:0] width_ff, width_in, height_ff, height_in;
   yuvnv_pkg::phase_type phase_ff, phase_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [31:0] luma_addr_ff, luma_addr_in;
   logic [31:0] u_addr_ff, u_addr_in;
   logic [31:0] v_addr_ff, v_addr_in;
   logic [31:0] dst_addr_ff, dst_addr_in;
   logic        take_u_ff, take_u_in;

   yuvnv_pkg::cmd_type cmd;
   logic [14:0] col_inc, row_inc;
   logic [14:0] luma_y, chroma_y;
   logic [13:0] half_w, half_h;
   logic        col_zero;
   logic        luma_fail, chroma_fail;
   logic        luma_col_end, luma_row_end, chroma_col_end, chroma_row_end;
   logic        dims_bad, size_bad;
   logic [27:0] area;
   logic [29:0] need_bytes;
   logic [31:0] luma_src, v_src;
   yuvnv_pkg::row_chk_type luma_chk, u_chk, v_chk;

   // First-sample offset of a row and whether its last sample lies below the limit.
   function automatic yuvnv_pkg::row_chk_type row_check(
      input logic [31:0] start,
      input logic [31:0] limit,
      input logic [15:0] lp,
      input logic [7:0]  sp,
      input logic [14:0] y,
      input logic [13:0] x,
      input logic [13:0] nm1
   );
      logic [30:0]                   ylp;
      logic [21:0]                   xsp;
      logic [21:0]                   lsp;
      logic [yuvnv_pkg::SUM_BITS-1:0] f;
      logic [yuvnv_pkg::SUM_BITS-1:0] last;
      yuvnv_pkg::row_chk_type        res;
      ylp = y * lp;
      xsp = x * sp;
      lsp = nm1 * sp;
      f = yuvnv_pkg::SUM_BITS'(start) + yuvnv_pkg::SUM_BITS'(ylp)
         + yuvnv_pkg::SUM_BITS'(xsp);
      last = f + yuvnv_pkg::SUM_BITS'(lsp);
      res.ok = (lp != 16'd0) && (sp != 8'd0) && (start <= limit)
         && (last < yuvnv_pkg::SUM_BITS'(limit));
      res.first = f[31:0];
      return res;
   endfunction

   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign cmd      = yuvnv_pkg::cmd_type'(in_data_ff.cmd);
   assign col_inc  = 15'(col_ff) + 15'd1;
   assign row_inc  = 15'(row_ff) + 15'd1;
   assign half_w   = {1'b0, width_ff[13:1]};
   assign half_h   = {1'b0, height_ff[13:1]};
   assign col_zero = (col_ff == '0);
   assign luma_y   = 15'(crop_y_ff) + 15'(row_ff);
   assign chroma_y = 15'(crop_y_ff[13:1]) + 15'(row_ff);

   assign luma_chk = row_check(32'(desc_start_ff[yuvnv_pkg::PLANE_Y]),
                               32'(desc_end_ff[yuvnv_pkg::PLANE_Y]),
                               desc_lp_ff[yuvnv_pkg::PLANE_Y],
                               desc_sp_ff[yuvnv_pkg::PLANE_Y],
                               luma_y, crop_x_ff, width_ff - 14'd1);
   assign u_chk = row_check(32'(desc_start_ff[yuvnv_pkg::PLANE_U]),
                            32'(desc_end_ff[yuvnv_pkg::PLANE_U]),
                            desc_lp_ff[yuvnv_pkg::PLANE_U],
                            desc_sp_ff[yuvnv_pkg::PLANE_U],
                            chroma_y, {1'b0, crop_x_ff[13:1]}, half_w - 14'd1);
   assign v_chk = row_check(32'(desc_start_ff[yuvnv_pkg::PLANE_V]),
                            32'(desc_end_ff[yuvnv_pkg::PLANE_V]),
                            desc_lp_ff[yuvnv_pkg::PLANE_V],
                            desc_sp_ff[yuvnv_pkg::PLANE_V],
                            chroma_y, {1'b0, crop_x_ff[13:1]}, half_w - 14'd1);

   assign luma_fail      = col_zero && !luma_chk.ok;
   assign chroma_fail    = col_zero && !take_u_ff && !(u_chk.ok && v_chk.ok);
   assign luma_col_end   = col_inc >= {1'b0, width_ff};
   assign luma_row_end   = row_inc >= {1'b0, height_ff};
   assign chroma_col_end = col_inc >= {1'b0, half_w};
   assign chroma_row_end = row_inc >= {1'b0, half_h};
   assign luma_src       = col_zero ? luma_chk.first : luma_addr_ff;
   assign v_src          = (col_zero && !take_u_ff) ? v_chk.first : v_addr_ff;

   assign dims_bad = (in_data_ff.frame_width == 14'd0) || (in_data_ff.frame_height == 14'd0)
      || in_data_ff.frame_width[0] || in_data_ff.frame_height[0]
      || in_data_ff.crop_x[0] || in_data_ff.crop_y[0]
      || ({1'b0, in_data_ff.frame_width} > 15'(MAX_WIDTH))
      || ({1'b0, in_data_ff.frame_height} > 15'(MAX_HEIGHT));
   // The area is even whenever the dimensions pass, so 3/2 of it is exact.
   assign area       = in_data_ff.frame_width * in_data_ff.frame_height;
   assign need_bytes = 30'(area) + 30'(area[27:1]);
   assign size_bad   = in_data_ff.out_bytes != 32'(need_bytes);

   // Next phase of the frame walker.
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         unique case (cmd)
            yuvnv_pkg::CMD_START: begin
               phase_in = (dims_bad || size_bad) ? yuvnv_pkg::PH_IDLE : yuvnv_pkg::PH_LUMA;
            end
            yuvnv_pkg::CMD_STEP: begin
               unique case (phase_ff)
                  yuvnv_pkg::PH_LUMA: begin
                     if (luma_fail) begin
                        phase_in = yuvnv_pkg::PH_IDLE;
                     end else if (luma_col_end && luma_row_end) begin
                        phase_in = yuvnv_pkg::PH_CHROMA;
                     end
                  end
                  yuvnv_pkg::PH_CHROMA: begin
                     if (chroma_fail) begin
                        phase_in = yuvnv_pkg::PH_IDLE;
                     end else if (take_u_ff && chroma_col_end && chroma_row_end) begin
                        phase_in = yuvnv_pkg::PH_IDLE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // Descriptors, counters, addresses and the result.
   always_comb begin
      desc_start_in = desc_start_ff;
      desc_end_in   = desc_end_ff;
      desc_lp_in    = desc_lp_ff;
      desc_sp_in    = desc_sp_ff;
      crop_x_in     = crop_x_ff;
      crop_y_in     = crop_y_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      luma_addr_in  = luma_addr_ff;
      u_addr_in     = u_addr_ff;
      v_addr_in     = v_addr_ff;
      dst_addr_in   = dst_addr_ff;
      take_u_in     = take_u_ff;
      rsp_in        = '0;
      rsp_in.status = (phase_ff == yuvnv_pkg::PH_IDLE) ? yuvnv_pkg::ST_IDLE : yuvnv_pkg::ST_OK;
      if (advance) begin
         unique case (cmd)
            yuvnv_pkg::CMD_LOAD: begin
               if (in_data_ff.plane_sel == yuvnv_pkg::PLANE_Y
                   || in_data_ff.plane_sel == yuvnv_pkg::PLANE_U
                   || in_data_ff.plane_sel == yuvnv_pkg::PLANE_V) begin
                  desc_start_in[in_data_ff.plane_sel] = in_data_ff.plane_start[DESC_BITS-1:0];
                  desc_end_in[in_data_ff.plane_sel]   = in_data_ff.plane_end[DESC_BITS-1:0];
                  desc_lp_in[in_data_ff.plane_sel]    = in_data_ff.line_pitch;
                  desc_sp_in[in_data_ff.plane_sel]    = in_data_ff.sample_pitch;
               end
            end
            yuvnv_pkg::CMD_START: begin
               if (dims_bad) begin
                  rsp_in.status = yuvnv_pkg::ST_BAD_DIMS;
               end else if (size_bad) begin
                  rsp_in.status = yuvnv_pkg::ST_BAD_SIZE;
               end else begin
                  rsp_in.status = yuvnv_pkg::ST_OK;
                  crop_x_in     = in_data_ff.crop_x;
                  crop_y_in     = in_data_ff.crop_y;
                  width_in      = in_data_ff.frame_width;
                  height_in     = in_data_ff.frame_height;
                  row_in        = '0;
                  col_in        = '0;
                  take_u_in     = 1'b0;
                  dst_addr_in   = '0;
               end
            end
            yuvnv_pkg::CMD_STEP: begin
               unique case (phase_ff)
                  yuvnv_pkg::PH_LUMA: begin
                     if (luma_fail) begin
                        rsp_in.status = yuvnv_pkg::ST_LUMA_BOUNDS;
                     end else begin
                        rsp_in.byte_valid = 1'b1;
                        rsp_in.src_plane  = yuvnv_pkg::PLANE_Y;
                        rsp_in.src_offset = luma_src;
                        rsp_in.dst_offset = dst_addr_ff;
                        dst_addr_in       = dst_addr_ff + 32'd1;
                        luma_addr_in      = luma_src + 32'(desc_sp_ff[yuvnv_pkg::PLANE_Y]);
                        col_in            = col_inc[COL_BITS-1:0];
                        if (luma_col_end) begin
                           col_in = '0;
                           row_in = row_inc[ROW_BITS-1:0];
                           if (luma_row_end) begin
                              row_in    = '0;
                              take_u_in = 1'b0;
                           end
                        end
                     end
                  end
                  yuvnv_pkg::PH_CHROMA: begin
                     if (chroma_fail) begin
                        rsp_in.status = yuvnv_pkg::ST_CHROMA_BOUNDS;
                     end else begin
                        rsp_in.byte_valid = 1'b1;
                        rsp_in.dst_offset = dst_addr_ff;
                        dst_addr_in       = dst_addr_ff + 32'd1;
                        if (!take_u_ff) begin
                           // V leads each pair; the row start also loads the U address.
                           if (col_zero) begin
                              u_addr_in = u_chk.first;
                           end
                           rsp_in.src_plane  = yuvnv_pkg::PLANE_V;
                           rsp_in.src_offset = v_src;
                           v_addr_in = v_src + 32'(desc_sp_ff[yuvnv_pkg::PLANE_V]);
                           take_u_in = 1'b1;
                        end else begin
                           rsp_in.src_plane  = yuvnv_pkg::PLANE_U;
                           rsp_in.src_offset = u_addr_ff;
                           u_addr_in = u_addr_ff + 32'(desc_sp_ff[yuvnv_pkg::PLANE_U]);
                           take_u_in = 1'b0;
                           col_in    = col_inc[COL_BITS-1:0];
                           if (chroma_col_end) begin
                              col_in = '0;
                              row_in = row_inc[ROW_BITS-1:0];
                              if (chroma_row_end) begin
                                 row_in            = '0;
                                 rsp_in.frame_last = 1'b1;
                              end
                           end
                        end
                     end
                  end
                  default: begin
                     rsp_in.status = yuvnv_pkg::ST_IDLE;
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_data_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            desc_start_ff[i] <= '0;
            desc_end_ff[i]   <= '0;
            desc_lp_ff[i]    <= '0;
            desc_sp_ff[i]    <= '0;
         end
         crop_x_ff    <= '0;
         crop_y_ff    <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         phase_ff     <= yuvnv_pkg::PH_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         luma_addr_ff <= '0;
         u_addr_ff    <= '0;
         v_addr_ff    <= '0;
         dst_addr_ff  <= '0;
         take_u_ff    <= 1'b0;
      end else begin
         desc_start_ff <= desc_start_in;
         desc_end_ff   <= desc_end_in;
         desc_lp_ff    <= desc_lp_in;
         desc_sp_ff    <= desc_sp_in;
         crop_x_ff     <= crop_x_in;
         crop_y_ff     <= crop_y_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         phase_ff      <= phase_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         luma_addr_ff  <= luma_addr_in;
         u_addr_ff     <= u_addr_in;
         v_addr_ff     <= v_addr_in;
         dst_addr_ff   <= dst_addr_in;
         take_u_ff     <= take_u_in;
      end
   end

endmodule

// ----- tb/tb_yuv420_to_nv21_address_generator.sv -----
// Self-checking testbench for yuv420_to_nv21_address_generator: descriptor loads, frame
// starts and byte steps are driven on req and checked on rsp against an in-bench predictor.
// Depends on yuvnv_pkg and the generator RTL.
module tb_yuv420_to_nv21_address_generator;
   import yuvnv_pkg::*;

   localparam int HOLD_CYCLES = 90;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type req_q[$];
   rsp_type rsp_due_q[$];
   rsp_type want;

   // Predictor state: plane descriptors, crop window and frame walker.
   logic [31:0] pl_base[3];
   logic [31:0] pl_limit[3];
   logic [15:0] pl_row_pitch[3];
   logic [7:0]  pl_col_pitch[3];
   logic [13:0] win_x, win_y, win_w, win_h;
   phase_type   walk_phase;
   int unsigned walk_row, walk_col;
   logic [63:0] y_ptr, u_ptr, v_ptr;
   logic [31:0] out_ptr;
   bit          u_turn;

   int  pushed = 0;
   int  accepted = 0;
   int  mismatch_cnt = 0;
   int  frames_done = 0;
   int  aborts = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_left = 0;
   bit  hold_arm = 1'b0;
   bit  tail_quiet = 1'b0;

   always #1 clock = ~clock;

   yuv420_to_nv21_address_generator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   function automatic void nv21_clear();
      for (int p = 0; p < 3; p++) begin
         pl_base[p] = '0;
         pl_limit[p] = '0;
         pl_row_pitch[p] = '0;
         pl_col_pitch[p] = '0;
      end
      win_x = '0; win_y = '0; win_w = '0; win_h = '0;
      walk_phase = PH_IDLE;
      walk_row = 0; walk_col = 0;
      y_ptr = '0; u_ptr = '0; v_ptr = '0; out_ptr = '0;
      u_turn = 1'b0;
   endfunction

   // True when n samples starting at sample x of row y stay below the plane limit.
   function automatic bit row_fits(input logic [1:0] p, input logic [63:0] x, y, n,
                                   output logic [63:0] row_base);
      logic [63:0] last_off;
      row_base = '0;
      if (pl_row_pitch[p] == 0 || pl_col_pitch[p] == 0 || n == 0 || pl_base[p] > pl_limit[p])
         return 1'b0;
      row_base = pl_base[p] + y * pl_row_pitch[p] + x * pl_col_pitch[p];
      last_off = row_base + (n - 1) * pl_col_pitch[p];
      return last_off < pl_limit[p];
   endfunction

   function automatic rsp_type nv21_next(input req_type r);
      rsp_type     o;
      logic [63:0] src, row_y, row_u, row_v, area;
      logic [1:0]  pl;
      int unsigned cw, ch;
      bit          last;
      o = '0;
      last = 1'b0;
      case (r.cmd)
         CMD_LOAD, CMD_NONE: begin
            if (r.cmd == CMD_LOAD && r.plane_sel <= PLANE_V) begin
               pl_base[r.plane_sel] = r.plane_start;
               pl_limit[r.plane_sel] = r.plane_end;
               pl_row_pitch[r.plane_sel] = r.line_pitch;
               pl_col_pitch[r.plane_sel] = r.sample_pitch;
            end
            o.status = (walk_phase == PH_IDLE) ? ST_IDLE : ST_OK;
            return o;
         end
         CMD_START: begin
            walk_phase = PH_IDLE;
            if (r.frame_width == 0 || r.frame_height == 0 || r.frame_width[0] ||
                r.frame_height[0] || r.crop_x[0] || r.crop_y[0] ||
                r.frame_width > MAX_WIDTH_DEFAULT || r.frame_height > MAX_HEIGHT_DEFAULT) begin
               o.status = ST_BAD_DIMS;
               return o;
            end
            area = r.frame_width;
            area = area * r.frame_height * 3 / 2;
            if (r.out_bytes != area) begin
               o.status = ST_BAD_SIZE;
               return o;
            end
            win_x = r.crop_x; win_y = r.crop_y; win_w = r.frame_width; win_h = r.frame_height;
            walk_phase = PH_LUMA;
            walk_row = 0; walk_col = 0;
            u_turn = 1'b0;
            out_ptr = '0;
            o.status = ST_OK;
            return o;
         end
         default: begin
            if (walk_phase == PH_LUMA) begin
               if (walk_col == 0) begin
                  if (!row_fits(PLANE_Y, win_x, win_y + walk_row, win_w, row_y)) begin
                     walk_phase = PH_IDLE;
                     o.status = ST_LUMA_BOUNDS;
                     return o;
                  end
                  y_ptr = row_y;
               end
               pl = PLANE_Y;
               src = y_ptr;
               y_ptr = y_ptr + pl_col_pitch[PLANE_Y];
               walk_col++;
               if (walk_col >= win_w) begin
                  walk_col = 0;
                  walk_row++;
                  if (walk_row >= win_h) begin
                     walk_row = 0;
                     walk_phase = PH_CHROMA;
                     u_turn = 1'b0;
                  end
               end
            end else if (walk_phase == PH_CHROMA) begin
               cw = win_w / 2;
               ch = win_h / 2;
               // Both chroma planes are checked before the V byte that opens a row.
               if (walk_col == 0 && !u_turn) begin
                  if (!row_fits(PLANE_U, win_x / 2, win_y / 2 + walk_row, cw, row_u) ||
                      !row_fits(PLANE_V, win_x / 2, win_y / 2 + walk_row, cw, row_v)) begin
                     walk_phase = PH_IDLE;
                     o.status = ST_CHROMA_BOUNDS;
                     return o;
                  end
                  u_ptr = row_u;
                  v_ptr = row_v;
               end
               if (!u_turn) begin
                  pl = PLANE_V;
                  src = v_ptr;
                  v_ptr = v_ptr + pl_col_pitch[PLANE_V];
                  u_turn = 1'b1;
               end else begin
                  pl = PLANE_U;
                  src = u_ptr;
                  u_ptr = u_ptr + pl_col_pitch[PLANE_U];
                  u_turn = 1'b0;
                  walk_col++;
                  if (walk_col >= cw) begin
                     walk_col = 0;
                     walk_row++;
                     if (walk_row >= ch) begin
                        walk_row = 0;
                        walk_phase = PH_IDLE;
                        last = 1'b1;
                     end
                  end
               end
            end else begin
               o.status = ST_IDLE;
               return o;
            end
            o.status = ST_OK;
            o.byte_valid = 1'b1;
            o.src_plane = pl;
            o.src_offset = src[31:0];
            o.dst_offset = out_ptr;
            o.frame_last = last;
            out_ptr = out_ptr + 1;
            return o;
         end
      endcase
   endfunction

   function automatic req_type random_req();
      req_type r;
      r.cmd = $urandom;
      r.plane_sel = $urandom;
      r.plane_start = $urandom;
      r.plane_end = $urandom;
      r.line_pitch = $urandom;
      r.sample_pitch = $urandom;
      r.crop_x = $urandom;
      r.crop_y = $urandom;
      r.frame_width = $urandom;
      r.frame_height = $urandom;
      r.out_bytes = $urandom;
      return r;
   endfunction

   task automatic push_load(input logic [1:0] p, input logic [31:0] s, e,
                            input logic [15:0] lp, input logic [7:0] sp);
      req_type r;
      r = random_req();
      r.cmd = CMD_LOAD;
      r.plane_sel = p;
      r.plane_start = s;
      r.plane_end = e;
      r.line_pitch = lp;
      r.sample_pitch = sp;
      req_q.push_back(r);
      pushed++;
   endtask

   task automatic push_start(input logic [13:0] cx, cy, w, h, input logic [31:0] ob);
      req_type r;
      r = random_req();
      r.cmd = CMD_START;
      r.crop_x = cx;
      r.crop_y = cy;
      r.frame_width = w;
      r.frame_height = h;
      r.out_bytes = ob;
      req_q.push_back(r);
      pushed++;
   endtask

   task automatic push_steps(input int n);
      req_type r;
      repeat (n) begin
         r = random_req();
         r.cmd = CMD_STEP;
         req_q.push_back(r);
         pushed++;
      end
   endtask

   // One frame with descriptors that mostly fit; now and then a plane is one byte short,
   // has a zero pitch, the size is off, or the frame is disturbed halfway.
   task automatic push_frame();
      int unsigned w, h, cx, cy, xs, ys, ns, rows, total, split;
      logic [63:0] ext, base, lim;
      logic [15:0] lp;
      logic [7:0]  sp;
      w = 2 * $urandom_range(1, 4);
      h = 2 * $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0) begin
         cx = 2 * $urandom_range(0, 8191);
         cy = 2 * $urandom_range(0, 8191);
      end else begin
         cx = 2 * $urandom_range(0, 6);
         cy = 2 * $urandom_range(0, 6);
      end
      for (int p = 0; p < 3; p++) begin
         xs = (p == PLANE_Y) ? cx : cx / 2;
         ys = (p == PLANE_Y) ? cy : cy / 2;
         ns = (p == PLANE_Y) ? w : w / 2;
         rows = (p == PLANE_Y) ? h : h / 2;
         lp = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 65535);
         sp = $urandom_range(1, 255);
         if ($urandom_range(0, 39) == 0)
            sp = '0;
         ext = (ys + rows - 1) * lp + (xs + ns - 1) * sp;
         base = $urandom_range(0, 32'hB000_0000);
         lim = base + ext + 1 + $urandom_range(0, 3);
         if ($urandom_range(0, 24) == 0)
            lim = base + ext;
         push_load(p, base[31:0], lim[31:0], lp, sp);
      end
      push_start(cx, cy, w, h, ($urandom_range(0, 19) == 0) ? w * h * 3 / 2 + 1 : w * h * 3 / 2);
      total = w * h * 3 / 2 + $urandom_range(0, 2);
      split = $urandom_range(0, total);
      push_steps(split);
      if ($urandom_range(0, 4) == 0)
         push_load($urandom_range(0, 2), $urandom_range(0, 32'h0FFF_FFFF), 32'hFFFF_FFFF,
                   $urandom_range(1, 65535), $urandom_range(1, 255));
      if ($urandom_range(0, 9) == 0) begin
         req_q.push_back(random_req());
         pushed++;
      end
      push_steps(total - split);
   endtask

   // Sender: offers queued transactions, with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            rsp_due_q.push_back(nv21_next(req_data));
            accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap--;
            end else if (req_q.size() != 0) begin
               req_data <= req_q.pop_front();
               req_valid <= 1'b1;
               if (!tail_quiet && $urandom_range(0, 99) < 6)
                  send_gap = $urandom_range(1, 14);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, armed once from the stimulus sequence.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_arm) begin
         hold_left <= HOLD_CYCLES;
      end
   end

   // Receiver: checks each result against the oldest prediction and stalls in bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_due_q.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("%0t: result with nothing outstanding: %p", $time, rsp_data);
            end else begin
               want = rsp_due_q.pop_front();
               if (rsp_data.status !== want.status || rsp_data.byte_valid !== want.byte_valid ||
                   rsp_data.src_plane !== want.src_plane ||
                   rsp_data.src_offset !== want.src_offset ||
                   rsp_data.dst_offset !== want.dst_offset ||
                   rsp_data.frame_last !== want.frame_last) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10)
                     $display("%0t: mismatch, expected st=%0d bv=%0d pl=%0d src=%h dst=%h last=%0d",
                              $time, want.status, want.byte_valid, want.src_plane,
                              want.src_offset, want.dst_offset, want.frame_last,
                              "\n   got st=%0d bv=%0d pl=%0d src=%h dst=%h last=%0d",
                              rsp_data.status, rsp_data.byte_valid, rsp_data.src_plane,
                              rsp_data.src_offset, rsp_data.dst_offset, rsp_data.frame_last);
               end
            end
            if (rsp_data.frame_last)
               frames_done++;
            if (rsp_data.status != ST_OK && rsp_data.status != ST_IDLE)
               aborts++;
         end
         if (recv_gap > 0)
            recv_gap--;
         else if (!tail_quiet && $urandom_range(0, 99) < 6)
            recv_gap = $urandom_range(1, 14);
         rsp_stall <= (recv_gap > 0) || (hold_left != 0);
      end
   end

   initial begin
      req_type r;
      int      guard;
      nv21_clear();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part: idle step, unused command, ignored plane select, both start rejection
      // statuses, bounds failures for each cause, and the largest accepted frame.
      push_steps(1);
      r = '1;
      r.cmd = CMD_NONE;
      req_q.push_back(r);
      r.cmd = CMD_LOAD;
      req_q.push_back(r);
      pushed += 2;
      push_start(0, 0, 0, 2, 0);
      push_start(0, 1, 2, 2, 6);
      push_start(0, 0, 8194, 2, 24582);
      push_start(0, 0, 2, 16382, 49146);
      push_start(0, 0, 2, 2, 7);
      push_start(0, 0, 2, 2, 6);                  // descriptors still hold zero pitches
      push_steps(1);
      push_load(PLANE_Y, 200, 100, 4, 1);         // start above limit
      push_start(0, 0, 2, 2, 6);
      push_steps(1);
      push_load(PLANE_Y, 0, 4, 2, 1);
      push_load(PLANE_U, 0, 1, 1, 1);
      push_load(PLANE_V, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1);
      push_start(0, 0, 2, 2, 6);
      push_steps(5);
      push_load(PLANE_Y, 0, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
      push_start(0, 0, 8192, 8192, 32'd100663296);
      push_steps(2);
      push_start(2, 2, 2, 2, 6);                  // restart in the middle of a frame
      push_steps(7);

      // Hold the sender back until every outstanding result has come home.
      while (req_q.size() != 0 || req_valid || rsp_due_q.size() != 0)
         @(negedge clock);

      // Receiver holds off for a long stretch while the sender keeps offering.
      hold_arm = 1'b1;
      push_frame();
      push_frame();
      while (hold_left == 0)
         @(negedge clock);
      hold_arm = 1'b0;

      while (pushed < 950) begin
         while (req_q.size() > 24)
            @(negedge clock);
         if (pushed > 840)
            tail_quiet = 1'b1;
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               req_q.push_back(random_req());
               pushed++;
            end
         end else begin
            push_frame();
         end
      end

      while (req_q.size() != 0 || req_valid)
         @(negedge clock);
      for (guard = 0; rsp_due_q.size() != 0 && guard < 20000; guard++)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (rsp_due_q.size() != 0) begin
         $display("%0d results never arrived", rsp_due_q.size());
         mismatch_cnt += rsp_due_q.size();
      end

      $display("Covered %0d transactions: %0d frames walked to their last byte, %0d rejected",
               accepted, frames_done, aborts);
      $display("or aborted by a bounds check, %0d mismatches.", mismatch_cnt);
      if (mismatch_cnt == 0)
         $display("yuv420_to_nv21_address_generator regression: pass");
      else
         $display("yuv420_to_nv21_address_generator regression: fail");
      $finish;
   end

   initial begin
      #1000000;
      $display("yuv420_to_nv21_address_generator regression: fail");
      $finish;
   end

endmodule
